// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the piezo kick detector.
// No dependencies; synthesis builds see empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/core/pkd_pkg.sv -----
// Package of the piezo kick detector: field widths, register indexes and
// fixed-point constants. No dependencies.
package pkd_pkg;

	localparam int CH_W      = 2;
	localparam int SAMPLE_W  = 12;
	localparam int TIME_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	typedef logic [CH_W-1:0]       chan_t;
	typedef logic [SAMPLE_W-1:0]   sample_t;
	typedef logic [TIME_W-1:0]     time_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_KICK_THR  = 2'd0;
	localparam cfg_idx_t REG_MOVE_THR  = 2'd1;
	localparam cfg_idx_t REG_FORCE_INT = 2'd2;

	localparam sample_t       BASE_RESET = 12'd2047;
	localparam logic [15:0]   KEEP_Q16   = 16'd62259;
	localparam logic [11:0]   STEP_Q16   = 12'd3277;

endpackage

// ----- rtl/core/pkd_if.sv -----
// Channel interfaces of the piezo kick detector: sample input, result output
// and register write. Depends on pkd_pkg.
interface pkd_smp_if
	import pkd_pkg::*;
	();
	logic    valid;
	logic    ready;
	chan_t   channel;
	sample_t sample;
	time_t   time_ms;
	modport source (output valid, channel, sample, time_ms, input ready);
	modport sink (input valid, channel, sample, time_ms, output ready);
endinterface

interface pkd_res_if
	import pkd_pkg::*;
	();
	logic    valid;
	logic    ready;
	chan_t   out_channel;
	logic    kick;
	logic    movement;
	sample_t baseline_out;
	modport source (output valid, out_channel, kick, movement, baseline_out, input ready);
	modport sink (input valid, out_channel, kick, movement, baseline_out, output ready);
endinterface

interface pkd_cfg_if
	import pkd_pkg::*;
	();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pkd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pkd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/pkd_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module pkd_div #(
	parameter int DIVIDEND_W = 18,
	parameter int DIVISOR_W = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quot_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;
	logic [DIVISOR_W-1:0]  rem_nx;

	always_comb begin
		trial  = {rem_q, quot_q[DIVIDEND_W-1]};
		diff   = trial - {1'b0, dsr_q};
		ge     = trial >= {1'b0, dsr_q};
		rem_nx = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			quot_q <= {quot_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- rtl/core/piezo_kick_detector.sv -----
// Top level of the piezo kick detector: per-channel baseline tracking and
// threshold flags. Depends on pkd_pkg, pkd_if, pkd_ram, pkd_div, assert_macros.svh.
//
// Usage: samples enter on smp (channel, sample, time_ms); one result word per
// sample leaves on res (out_channel, kick, movement, baseline_out). Registers
// are written on cfg (index 0 kick threshold, 1 movement threshold, 2 force
// interval in ms); cfg is always ready. The user must see that writes are made
// only while idle; the block does not enforce this. A sample whose channel is
// not configured is dropped with no result. A rest sample passes the look-up,
// evaluate, divide and done steps, the divide step waiting on the bit-serial
// divider that forms the window mean. A moving sample skips the divider and
// takes the drift step only when its force interval has run out. One sample is
// in flight at a time: a new one is accepted once the last result is loaded.
// Channel state lives in a small RAM with per-channel valid bits, and the
// window samples in a second RAM of NCH x 2**POS_W entries. Reset clears the
// valid bits, so every channel starts with an empty window and a baseline of
// 2047; no clearing pass is needed. A finished result waits in the output
// register while res is stalled; the next sample is accepted meanwhile and
// holds in its last step until the output register frees.
module piezo_kick_detector
	import pkd_pkg::*;
#(
	parameter int WINDOW_LEN = 64,
	parameter int NUM_CHANNELS = 4
) (
	input logic clk,
	input logic arst_n,
	pkd_smp_if.sink   smp,
	pkd_res_if.source res,
	pkd_cfg_if.sink   cfg
);

	`include "assert_macros.svh"

	localparam int NCH       = (NUM_CHANNELS < (2 ** CH_W)) ? NUM_CHANNELS : (2 ** CH_W);
	localparam int CA_W      = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int POS_W     = $clog2(WINDOW_LEN);
	localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
	localparam int WIN_DEPTH = NCH * (2 ** POS_W);
	localparam int WA_W      = $clog2(WIN_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_DRIFT = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [POS_W-1:0] pos;
		logic             full;
		sample_t          base;
		time_t            rest_time;
	} chst_t;

	localparam int ST_W = $bits(chst_t);

	logic [2:0]   state_q;
	logic [NCH-1:0] chan_vld_q;
	sample_t      kick_thr_q;
	sample_t      move_thr_q;
	time_t        force_int_q;

	chan_t        ch_q;
	sample_t      smp_q;
	time_t        time_q;
	chst_t        st_q;
	logic         kick_q;
	logic         move_q;
	time_t        elapsed_q;
	logic [27:0]  keep_q;
	logic [23:0]  step_q;

	logic         out_vld_q;
	chan_t        out_ch_q;
	logic         out_kick_q;
	logic         out_move_q;
	sample_t      out_base_q;

	logic         accept;
	logic         ch_ok;
	logic [CA_W-1:0] ch_idx;
	logic [ST_W-1:0] st_rdata;
	chst_t        st_rd;
	chst_t        st_reset;
	sample_t      dev;
	logic [SAMPLE_W-1:0] win_rdata;
	logic [WA_W-1:0] win_addr;
	logic         win_we;
	logic         ld;
	logic [SUM_W-1:0] sum_new;
	logic [POS_W-1:0] pos_new;
	logic         wrap;
	logic         full_new;
	logic [CNT_W-1:0] cnt_new;
	logic         div_start;
	logic         div_done;
	logic [SUM_W-1:0] div_quot;
	logic [28:0]  drift_sum;

	assign cfg.ready = 1'b1;
	assign smp.ready = (state_q == S_IDLE);
	assign accept    = smp.valid && smp.ready;
	assign ch_ok     = {1'b0, smp.channel} < (CH_W + 1)'(NCH);
	assign ch_idx    = ch_q[CA_W-1:0];
	assign ld        = (state_q == S_DONE) && (!out_vld_q || res.ready);
	assign win_addr  = WA_W'({ch_idx, st_q.pos});
	assign win_we    = (state_q == S_EVAL) && !move_q;
	assign div_start = win_we;

	always_comb begin
		st_reset           = '0;
		st_reset.base      = BASE_RESET;
		st_rd              = chan_vld_q[ch_idx] ? chst_t'(st_rdata) : st_reset;
		dev                = (smp_q >= st_rd.base) ? (smp_q - st_rd.base) : (st_rd.base - smp_q);
		wrap               = (st_q.pos == POS_W'(WINDOW_LEN - 1));
		pos_new            = wrap ? '0 : (st_q.pos + 1'b1);
		full_new           = st_q.full || wrap;
		cnt_new            = full_new ? CNT_W'(WINDOW_LEN) : CNT_W'(pos_new);
		sum_new            = st_q.sum - (st_q.full ? SUM_W'(win_rdata) : '0) + SUM_W'(smp_q);
		drift_sum          = 29'(keep_q) + 29'(step_q);
	end

	pkd_ram #(
		.WIDTH(ST_W),
		.DEPTH(NCH)
	) u_st_ram (
		.clk   (clk),
		.we    (ld),
		.waddr (ch_idx),
		.wdata (st_q),
		.re    (accept),
		.raddr (smp.channel[CA_W-1:0]),
		.rdata (st_rdata)
	);

	pkd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WIN_DEPTH)
	) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_addr),
		.wdata (smp_q),
		.re    (state_q == S_LOOK),
		.raddr (WA_W'({ch_idx, st_rd.pos})),
		.rdata (win_rdata)
	);

	pkd_div #(
		.DIVIDEND_W(SUM_W),
		.DIVISOR_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_new),
		.divisor  (cnt_new),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chan_vld_q  <= '0;
			kick_thr_q  <= '0;
			move_thr_q  <= '0;
			force_int_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_KICK_THR:  kick_thr_q  <= cfg.data[SAMPLE_W-1:0];
					REG_MOVE_THR:  move_thr_q  <= cfg.data[SAMPLE_W-1:0];
					REG_FORCE_INT: force_int_q <= cfg.data[TIME_W-1:0];
					default: ;
				endcase
			end
			if (ld) begin
				chan_vld_q[ch_idx] <= 1'b1;
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && ch_ok) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_EVAL;
				S_EVAL: begin
					if (!move_q) begin
						state_q <= S_DIV;
					end else if (elapsed_q > force_int_q) begin
						state_q <= S_DRIFT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DRIFT: state_q <= S_DONE;
				S_DONE: begin
					if (ld) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= smp.channel;
			smp_q  <= smp.sample;
			time_q <= smp.time_ms;
		end
		if (state_q == S_LOOK) begin
			st_q      <= st_rd;
			kick_q    <= dev >= kick_thr_q;
			move_q    <= dev >= move_thr_q;
			elapsed_q <= time_q - st_rd.rest_time;
		end
		if (state_q == S_EVAL) begin
			if (!move_q) begin
				st_q.sum       <= sum_new;
				st_q.pos       <= pos_new;
				st_q.full      <= full_new;
				st_q.rest_time <= time_q;
			end else if (elapsed_q > force_int_q) begin
				st_q.rest_time <= time_q;
				keep_q <= 28'(st_q.base) * 28'(KEEP_Q16);
				step_q <= 24'(smp_q) * 24'(STEP_Q16);
			end
		end
		if ((state_q == S_DIV) && div_done) begin
			st_q.base <= div_quot[SAMPLE_W-1:0];
		end
		if (state_q == S_DRIFT) begin
			st_q.base <= drift_sum[16 +: SAMPLE_W];
		end
		if (ld) begin
			out_ch_q   <= ch_q;
			out_kick_q <= kick_q;
			out_move_q <= move_q;
			out_base_q <= st_q.base;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.out_channel  = out_ch_q;
	assign res.kick         = out_kick_q;
	assign res.movement     = out_move_q;
	assign res.baseline_out = out_base_q;

	`ASSERT_NEVER(a_div_done_in_div, clk, arst_n, div_done && (state_q != S_DIV), "divider finished outside its wait state")
	`ASSERT_NEVER(a_win_write_rest, clk, arst_n, win_we && move_q, "window written for a moving sample")
	`ASSERT_PROP(a_load_to_idle, clk, arst_n, ld |=> (state_q == S_IDLE) && out_vld_q, "result load did not free the datapath")
	`ASSERT_PROP(a_no_accept_busy, clk, arst_n, (state_q != S_IDLE) |-> !smp.ready, "sample taken while one is in flight")

endmodule

// ----- tb/sv/piezo_kick_detector_tb.sv -----
// Testbench of the piezo kick detector: a directed table, then random phases; each result
// word is checked against its typed table entry or else a built-in model of the baseline
// tracker. Depends on pkd_pkg, the channel interfaces of pkd_if and piezo_kick_detector.
module piezo_kick_detector_tb;
	import pkd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_LEN = 64;
	localparam int NUM_CH = 4;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int DIRECTED_ROWS = 23;
	localparam cfg_idx_t REG_UNUSED = 2'd3;

	typedef struct packed {
		chan_t   channel;
		logic    kick;
		logic    movement;
		sample_t baseline;
	} kick_result_t;

	typedef struct packed {
		bit           is_cfg;
		cfg_idx_t     idx;
		cfg_data_t    data;
		chan_t        channel;
		sample_t      sample;
		time_t        stamp;
		bit           typed;
		kick_result_t result;
	} stim_row_t;

	localparam kick_result_t NO_RES = '{2'd0, 1'b0, 1'b0, 12'd0};

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{1'b0, REG_KICK_THR, 32'd0, 2'd0, 12'd2047, 32'd0, 1'b1,
			'{2'd0, 1'b1, 1'b1, 12'd2047}},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd1, 12'd4095, 32'd0, 1'b1,
			'{2'd1, 1'b1, 1'b1, 12'd2047}},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd3, 12'd0, 32'd0, 1'b1,
			'{2'd3, 1'b1, 1'b1, 12'd2047}},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd2, 12'd0, 32'd1, 1'b0, NO_RES},
		'{1'b1, REG_KICK_THR, 32'd4095, 2'd0, 12'd0, 32'd0, 1'b0, NO_RES},
		'{1'b1, REG_MOVE_THR, 32'd4095, 2'd0, 12'd0, 32'd0, 1'b0, NO_RES},
		'{1'b1, REG_FORCE_INT, 32'hFFFF_FFFF, 2'd0, 12'd0, 32'd0, 1'b0, NO_RES},
		'{1'b1, REG_UNUSED, 32'd0, 2'd0, 12'd0, 32'd0, 1'b0, NO_RES},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd0, 12'd0, 32'd100, 1'b1,
			'{2'd0, 1'b0, 1'b0, 12'd0}},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd0, 12'd4095, 32'd200, 1'b1,
			'{2'd0, 1'b1, 1'b1, 12'd0}},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd0, 12'd4095, 32'hFFFF_FFFF, 1'b1,
			'{2'd0, 1'b1, 1'b1, 12'd0}},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd1, 12'd4095, 32'd5, 1'b1,
			'{2'd1, 1'b0, 1'b0, 12'd4095}},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd1, 12'd0, 32'd6, 1'b1,
			'{2'd1, 1'b1, 1'b1, 12'd4095}},
		'{1'b1, REG_FORCE_INT, 32'd0, 2'd0, 12'd0, 32'd0, 1'b0, NO_RES},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd1, 12'd0, 32'd6, 1'b0, NO_RES},
		'{1'b1, REG_MOVE_THR, 32'd1, 2'd0, 12'd0, 32'd0, 1'b0, NO_RES},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd3, 12'd2047, 32'd7, 1'b1,
			'{2'd3, 1'b0, 1'b0, 12'd2047}},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd3, 12'd2048, 32'd8, 1'b0, NO_RES},
		'{1'b1, REG_KICK_THR, 32'd0, 2'd0, 12'd0, 32'd0, 1'b0, NO_RES},
		'{1'b1, REG_FORCE_INT, 32'd10, 2'd0, 12'd0, 32'd0, 1'b0, NO_RES},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd2, 12'd1000, 32'd20, 1'b0, NO_RES},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd2, 12'd4095, 32'd25, 1'b0, NO_RES},
		'{1'b0, REG_KICK_THR, 32'd0, 2'd0, 12'd4095, 32'd300, 1'b0, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n;

	pkd_smp_if smp_ch ();
	pkd_res_if res_ch ();
	pkd_cfg_if cfg_ch ();

	piezo_kick_detector #(
		.WINDOW_LEN(WIN_LEN),
		.NUM_CHANNELS(NUM_CH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.smp(smp_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	always #5ns clk = ~clk;

	sample_t     kick_thr;
	sample_t     move_thr;
	time_t       force_ms;
	logic [11:0] win_mem [NUM_CH][WIN_LEN];
	logic [17:0] sum_q [NUM_CH];
	logic [5:0]  wpos_q [NUM_CH];
	logic        full_q [NUM_CH];
	sample_t     base_q [NUM_CH];
	time_t       rest_time_q [NUM_CH];

	kick_result_t pending_results [$];
	kick_result_t head_res;
	bit quiet;
	int mismatches;
	int cycles;
	int samples_sent;
	int reg_writes;
	int rest_updates;
	int forced_drifts;
	int window_wraps;

	function automatic kick_result_t compute_kick_result(chan_t ch, sample_t s, time_t now);
		kick_result_t r;
		sample_t b;
		sample_t d;
		logic [5:0] pos;
		logic [17:0] count;
		logic [31:0] mix;
		b = base_q[ch];
		d = (s >= b) ? s - b : b - s;
		r.channel = ch;
		r.kick = (d >= kick_thr);
		r.movement = (d >= move_thr);
		if (!r.movement) begin
			pos = wpos_q[ch];
			if (full_q[ch])
				sum_q[ch] = sum_q[ch] - 18'(win_mem[ch][pos]);
			win_mem[ch][pos] = s;
			sum_q[ch] = sum_q[ch] + 18'(s);
			pos = pos + 6'd1;
			wpos_q[ch] = pos;
			if (pos == 6'd0) begin
				if (!full_q[ch])
					window_wraps++;
				full_q[ch] = 1'b1;
			end
			count = full_q[ch] ? 18'(WIN_LEN) : 18'(pos);
			base_q[ch] = sample_t'(sum_q[ch] / count);
			rest_time_q[ch] = now;
			rest_updates++;
		end else if (time_t'(now - rest_time_q[ch]) > force_ms) begin
			mix = 32'(b) * 32'(KEEP_Q16) + 32'(s) * 32'(STEP_Q16);
			base_q[ch] = mix[27:16];
			rest_time_q[ch] = now;
			forced_drifts++;
		end
		r.baseline = base_q[ch];
		return r;
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		smp_ch.valid = 1'b0;
		cfg_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		@(negedge clk);
		smp_ch.valid = 1'b0;
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_KICK_THR: kick_thr = val[11:0];
			REG_MOVE_THR: move_thr = val[11:0];
			REG_FORCE_INT: force_ms = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic send_sample(input chan_t ch, input sample_t s, input time_t stamp,
			input bit typed, input kick_result_t typed_res);
		kick_result_t r;
		int gap;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		if (!quiet && $urandom_range(0, 99) < 25) begin
			smp_ch.valid = 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
		smp_ch.valid = 1'b1;
		smp_ch.channel = ch;
		smp_ch.sample = s;
		smp_ch.time_ms = stamp;
		@(posedge clk);
		while (smp_ch.ready !== 1'b1)
			@(posedge clk);
		r = compute_kick_result(ch, s, stamp);
		pending_results.push_back(typed ? typed_res : r);
		samples_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result word with no sample outstanding, out_channel %0d",
					res_ch.out_channel);
				mismatches++;
			end else begin
				head_res = pending_results.pop_front();
				if (res_ch.out_channel !== head_res.channel) begin
					$error("out_channel: expected %0d, actual %0d",
						head_res.channel, res_ch.out_channel);
					mismatches++;
				end
				if (res_ch.kick !== head_res.kick) begin
					$error("kick: expected %0d, actual %0d", head_res.kick, res_ch.kick);
					mismatches++;
				end
				if (res_ch.movement !== head_res.movement) begin
					$error("movement: expected %0d, actual %0d",
						head_res.movement, res_ch.movement);
					mismatches++;
				end
				if (res_ch.baseline_out !== head_res.baseline) begin
					$error("baseline_out: expected %0d, actual %0d",
						head_res.baseline, res_ch.baseline_out);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready = 1'b0;
				stall_left--;
			end else if (!quiet && arst_n === 1'b1 && $urandom_range(0, 99) < 20) begin
				res_ch.ready = 1'b0;
				stall_left = $urandom_range(1, 12) - 1;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		chan_t ch;
		sample_t s;
		time_t stamp;
		int pick;
		int delta;
		int val;
		sample_t ph_kick;
		sample_t ph_move;
		time_t ph_force;
		arst_n = 1'b0;
		smp_ch.valid = 1'b0;
		smp_ch.channel = '0;
		smp_ch.sample = '0;
		smp_ch.time_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		quiet = 1'b0;
		mismatches = 0;
		samples_sent = 0;
		reg_writes = 0;
		rest_updates = 0;
		forced_drifts = 0;
		window_wraps = 0;
		kick_thr = '0;
		move_thr = '0;
		force_ms = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			sum_q[i] = '0;
			wpos_q[i] = '0;
			full_q[i] = 1'b0;
			base_q[i] = BASE_RESET;
			rest_time_q[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].is_cfg) begin
				if (i == 0 || !DIRECTED[i-1].is_cfg)
					wait_idle();
				write_reg(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				send_sample(DIRECTED[i].channel, DIRECTED[i].sample, DIRECTED[i].stamp,
					DIRECTED[i].typed, DIRECTED[i].result);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: ph_kick = 12'd0;
				1: ph_kick = 12'd4095;
				default: ph_kick = sample_t'($urandom_range(0, 600));
			endcase
			if (ph == 2)
				ph_move = 12'd0;
			else if (ph == 5)
				ph_move = 12'd4095;
			else
				ph_move = sample_t'($urandom_range(8, 250));
			case (ph % 4)
				0: ph_force = 32'd0;
				1: ph_force = 32'hFFFF_FFFF;
				2: ph_force = time_t'($urandom_range(0, 300));
				default: ph_force = time_t'($urandom);
			endcase
			wait_idle();
			quiet = (ph == 3 || ph == PHASES - 1);
			write_reg(REG_KICK_THR, cfg_data_t'(ph_kick));
			write_reg(REG_MOVE_THR, cfg_data_t'(ph_move));
			write_reg(REG_FORCE_INT, ph_force);
			stamp = (ph == 1) ? 32'hFFFF_FE00 : time_t'($urandom);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				ch = chan_t'($urandom_range(0, NUM_CH - 1));
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					s = sample_t'($urandom_range(0, 4095));
				end else begin
					if (pick < 75)
						delta = (move_thr == 0) ? 0 : int'($urandom_range(0, move_thr - 1));
					else
						delta = int'(move_thr) + int'($urandom_range(0, 4)) - 2;
					if (delta < 0)
						delta = 0;
					if ($urandom_range(0, 1))
						val = int'(base_q[ch]) + delta;
					else
						val = int'(base_q[ch]) - delta;
					if (val < 0)
						val = 0;
					else if (val > 4095)
						val = 4095;
					s = sample_t'(val);
				end
				stamp = stamp + time_t'($urandom_range(0, 40));
				if ($urandom_range(0, 99) < 5)
					stamp = stamp + time_t'($urandom);
				send_sample(ch, s, stamp, 1'b0, NO_RES);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d samples over %0d register writes in %0d cycles.",
			samples_sent, reg_writes, cycles);
		$display("Window updates %0d, forced baseline drifts %0d, window wraps %0d.",
			rest_updates, forced_drifts, window_wraps);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
